### src/lfm_pkg.sv
// shared types, codes and fingerprint constants for the line fingerprint matcher
package lfm_pkg;

  // window depth in characters and number of fingerprints
  localparam int WIN_DEPTH = 30;
  localparam int NPAT      = 4;

  typedef logic [7:0]             byte_t;
  typedef logic [NPAT-1:0]        hit_t;
  typedef logic [WIN_DEPTH*8-1:0] pat_word_t;

  // command codes
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_HANGUP = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  // status codes
  localparam logic [2:0] ST_PENDING     = 3'd0;
  localparam logic [2:0] ST_FOUND       = 3'd1;
  localparam logic [2:0] ST_LIMIT       = 3'd2;
  localparam logic [2:0] ST_PEER_CLOSED = 3'd3;
  localparam logic [2:0] ST_IGNORED     = 3'd4;

  // special characters
  localparam byte_t CH_NUL = 8'h00;
  localparam byte_t CH_LF  = 8'h0A;
  localparam byte_t CH_CR  = 8'h0D;

  // read limit after reset
  localparam logic [15:0] READ_LIMIT_RST = 16'd4096;

  // fingerprints, last character in the low byte so byte k lines up with window cell k
  localparam pat_word_t PAT_TEXT [NPAT] = '{
    pat_word_t'("HTTP/1.1 301 Moved Permanently"),
    pat_word_t'({"Location: ", 96'h6D696E646A61696C2E7A6970}),
    pat_word_t'("Content-Type: application/zip"),
    pat_word_t'("X-Pad: avoid browser bug")
  };

  localparam int PAT_LEN [NPAT] = '{30, 22, 29, 24};

endpackage

### src/lfm_cell.sv
// one window cell: holds one character and compares its incoming character
module lfm_cell import lfm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  logic  clr,
  input  byte_t din,
  output byte_t q,
  output hit_t  hit
);

  byte_t q_r;

  // character storage, loaded on every shift from the neighbor (cell 0: the input byte)
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= din;
    end
  end

  assign q = q_r;

  // compare the character this cell takes on a shift; positions past a pattern end pass
  always_comb begin
    for (int p = 0; p < NPAT; p++) begin
      hit[p] = (IDX >= PAT_LEN[p]) || (din == PAT_TEXT[p][IDX*8 +: 8]);
    end
  end

endmodule

### src/line_fingerprint_matcher.sv
// top level of the line fingerprint matcher
// Takes one word per clock (command plus received byte) and returns exactly one result word
// per input word in the cycle after acceptance, through a one-entry output register; with the
// output taken every cycle the block sustains one word per cycle. The last 30 kept characters
// of the line sit in a chain of 30 cells that all shift on each kept character and compare
// against the four fingerprints in parallel; hits are gathered per line and the
// lowest-numbered one is latched at LF. read_limit may be written only while idle.
module line_fingerprint_matcher import lfm_pkg::*; #(
  parameter int LINE_LEN = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_match_flags,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int LEN_W = $clog2(LINE_LEN + 1);

  logic [15:0]      read_limit_r;
  logic [LEN_W-1:0] line_length_r, line_length_nxt;
  logic [15:0]      bytes_seen_r, bytes_seen_nxt, bytes_inc;
  hit_t             line_hits_r, line_hits_nxt;
  hit_t             found_flags_r, found_flags_nxt;
  logic             closed_r, closed_nxt;
  logic             out_valid_r;
  logic [2:0]       out_status_r, status_nxt;
  logic [3:0]       out_flags_r;

  logic             accept;
  logic             shift_en, clr_win;
  logic [LEN_W-1:0] len_inc;
  hit_t             win_hit, pat_hit, first_hit;

  byte_t            cell_din [WIN_DEPTH];
  byte_t            cell_q   [WIN_DEPTH];
  hit_t             cell_hit [WIN_DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // window chain
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_din[k] = in_data_byte;
    end else begin : g_link
      assign cell_din[k] = cell_q[k-1];
    end
    lfm_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .clr      (clr_win),
      .din      (cell_din[k]),
      .q        (cell_q[k]),
      .hit      (cell_hit[k])
    );
  end

  // combine cell compares into full-pattern hits
  assign len_inc = line_length_r + LEN_W'(1);
  always_comb begin
    win_hit = '1;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      win_hit = win_hit & cell_hit[k];
    end
    for (int p = 0; p < NPAT; p++) begin
      pat_hit[p] = win_hit[p] && (len_inc >= LEN_W'(PAT_LEN[p]));
    end
  end

  // lowest-numbered hit of the line
  assign first_hit = line_hits_r & (~line_hits_r + hit_t'(1));
  assign bytes_inc = (bytes_seen_r != 16'hFFFF) ? bytes_seen_r + 16'd1 : bytes_seen_r;

  // per-word state update
  always_comb begin
    line_length_nxt = line_length_r;
    bytes_seen_nxt  = bytes_seen_r;
    line_hits_nxt   = line_hits_r;
    found_flags_nxt = found_flags_r;
    closed_nxt      = closed_r;
    status_nxt      = ST_PENDING;
    shift_en        = 1'b0;
    clr_win         = 1'b0;
    if (in_command == CMD_START) begin
      line_length_nxt = '0;
      bytes_seen_nxt  = '0;
      line_hits_nxt   = '0;
      found_flags_nxt = '0;
      closed_nxt      = 1'b0;
      clr_win         = accept;
    end else if (closed_r) begin
      status_nxt = ST_IGNORED;
    end else if (in_command == CMD_HANGUP) begin
      closed_nxt = 1'b1;
      status_nxt = ST_PEER_CLOSED;
    end else if (in_command == CMD_BYTE) begin
      bytes_seen_nxt = bytes_inc;
      if (bytes_inc >= read_limit_r) begin
        closed_nxt = 1'b1;
        status_nxt = ST_LIMIT;
      end else if (in_data_byte == CH_NUL || in_data_byte == CH_CR) begin
        // dropped
      end else if (in_data_byte == CH_LF) begin
        found_flags_nxt = found_flags_r | first_hit;
        line_hits_nxt   = '0;
        line_length_nxt = '0;
        if ((found_flags_r | first_hit) != '0) begin
          closed_nxt = 1'b1;
          status_nxt = ST_FOUND;
        end
      end else if (line_length_r < LEN_W'(LINE_LEN)) begin
        shift_en        = accept;
        line_length_nxt = len_inc;
        line_hits_nxt   = line_hits_r | pat_hit;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= '0;
      bytes_seen_r  <= '0;
      line_hits_r   <= '0;
      found_flags_r <= '0;
      closed_r      <= 1'b0;
    end else if (accept) begin
      line_length_r <= line_length_nxt;
      bytes_seen_r  <= bytes_seen_nxt;
      line_hits_r   <= line_hits_nxt;
      found_flags_r <= found_flags_nxt;
      closed_r      <= closed_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_limit_r <= READ_LIMIT_RST;
    end else if (cfg_wr_en) begin
      read_limit_r <= cfg_wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_flags_r  <= found_flags_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_flags = out_flags_r;

endmodule

### src/lfm_checker.sv
// port-level checks for the line fingerprint matcher and their binding
module lfm_checker import lfm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [3:0] out_match_flags
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_match_flags))
    else $error("result word changed while stalled");

  // with no result pending the input side is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // start clears everything
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_START |=>
      out_valid && out_status == ST_PENDING && out_match_flags == 4'd0)
    else $error("start word did not clear state");

  // hang-up closes or is ignored
  a_hangup: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_HANGUP |=>
      out_valid && (out_status == ST_PEER_CLOSED || out_status == ST_IGNORED))
    else $error("hang-up word gave wrong status");

  // a found proxy always carries a flag
  a_found_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FOUND |-> out_match_flags != 4'd0)
    else $error("proxy found without match flags");

endmodule

bind line_fingerprint_matcher lfm_checker u_lfm_checker (.*);
